/* hdl/hctmr_pkg.sv */
`default_nettype none
package hctmr_pkg;

    // Item actions
    typedef enum logic [2:0] {
        ACT_TICK    = 3'd0,
        ACT_WR_DIV  = 3'd1,
        ACT_WR_TAC  = 3'd2,
        ACT_WR_TIMA = 3'd3,
        ACT_WR_TMA  = 3'd4
    } act_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COUNT,
        ST_LOAD
    } st_t;

    // Controller to datapath commands
    typedef struct packed {
        logic start;
        logic step;
        logic load;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic count_zero;
    } status_t;

    // Divider bit tapped for each TAC rate select
    localparam logic [3:0] SEL_BIT_0 = 4'd9;
    localparam logic [3:0] SEL_BIT_1 = 4'd3;
    localparam logic [3:0] SEL_BIT_2 = 4'd5;
    localparam logic [3:0] SEL_BIT_3 = 4'd7;

    localparam logic [2:0] RELOAD_CYCLES = 3'd4;
    localparam logic [7:0] TIMA_MAX      = 8'hFF;

endpackage
`default_nettype wire

/* hdl/handheld_console_timer_top.sv */
// Divider/TIMA timer of a handheld console. Each input beat is one action: a tick that
// advances the divider by s_cycles, or a write of DIV, TAC, TIMA or TMA (other codes are
// no-ops); each gives one result beat with the divider's upper byte, TIMA, TMA, TAC and
// whether this action raised the timer interrupt. A tick steps the divider one emulated
// cycle per clock with the single divider incrementer, which the controller steps until
// the tick's count reaches zero. A finished result waits in an output register, and the
// next action is accepted in the cycle that result is taken.
`default_nettype none
module handheld_console_timer_top (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_valid,
    output logic       s_ready,
    input  wire [2:0]  s_action,
    input  wire [7:0]  s_cycles,
    input  wire [7:0]  s_write_data,
    output logic       m_valid,
    input  wire        m_ready,
    output logic [7:0] m_div_value,
    output logic [7:0] m_tima_value,
    output logic [7:0] m_tma_value,
    output logic [2:0] m_tac_value,
    output logic       m_timer_irq
);

    hctmr_pkg::cmd_t    cmd;
    hctmr_pkg::status_t status;

    // Sequencer
    hctmr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Timer registers and result beat
    hctmr_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .s_action     (s_action),
        .s_cycles     (s_cycles),
        .s_write_data (s_write_data),
        .m_div_value  (m_div_value),
        .m_tima_value (m_tima_value),
        .m_tma_value  (m_tma_value),
        .m_tac_value  (m_tac_value),
        .m_timer_irq  (m_timer_irq)
    );

endmodule
`default_nettype wire

/* hdl/hctmr_ctrl.sv */
`default_nettype none
module hctmr_ctrl (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  wire                 m_ready,
    input  hctmr_pkg::status_t  status,
    output hctmr_pkg::cmd_t     cmd
);

    hctmr_pkg::st_t state_reg, state_next;
    logic           m_valid_reg, m_valid_next;

    // State and result-valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= hctmr_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            hctmr_pkg::ST_IDLE: begin
                s_ready = !m_valid_reg || m_ready;
                if (s_valid && s_ready) begin
                    cmd.start  = 1'b1;
                    state_next = hctmr_pkg::ST_COUNT;
                end
            end
            hctmr_pkg::ST_COUNT: begin
                if (status.count_zero) begin
                    state_next = hctmr_pkg::ST_LOAD;
                end else begin
                    cmd.step = 1'b1;
                end
            end
            hctmr_pkg::ST_LOAD: begin
                cmd.load     = 1'b1;
                m_valid_next = 1'b1;
                state_next   = hctmr_pkg::ST_IDLE;
            end
            default: begin
                state_next = hctmr_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule
`default_nettype wire

/* hdl/hctmr_dp.sv */
`default_nettype none
module hctmr_dp (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  hctmr_pkg::cmd_t     cmd,
    output hctmr_pkg::status_t  status,
    input  wire [2:0]           s_action,
    input  wire [7:0]           s_cycles,
    input  wire [7:0]           s_write_data,
    output logic [7:0]          m_div_value,
    output logic [7:0]          m_tima_value,
    output logic [7:0]          m_tma_value,
    output logic [2:0]          m_tac_value,
    output logic                m_timer_irq
);

    logic [15:0] divider_reg, divider_next;
    logic [7:0]  tima_reg, tima_next;
    logic [7:0]  tma_reg, tma_next;
    logic [2:0]  tac_reg, tac_next;
    logic [2:0]  delay_reg, delay_next;
    logic [2:0]  ctl_reg, ctl_next;
    logic [7:0]  count_reg, count_next;
    logic        irq_reg, irq_next;

    logic [7:0]  div_out_reg, tima_out_reg, tma_out_reg;
    logic [2:0]  tac_out_reg;
    logic        irq_out_reg;

    logic [15:0] divider_inc;
    logic        do_bump;

    // Timer input: selected divider bit, gated by enable
    function automatic logic timer_in(input logic [2:0] ctl, input logic [15:0] d);
        logic [3:0] sel;
        case (ctl[1:0])
            2'd0:    sel = hctmr_pkg::SEL_BIT_0;
            2'd1:    sel = hctmr_pkg::SEL_BIT_1;
            2'd2:    sel = hctmr_pkg::SEL_BIT_2;
            default: sel = hctmr_pkg::SEL_BIT_3;
        endcase
        return ctl[2] & d[sel];
    endfunction

    assign divider_inc = divider_reg + 16'd1;

    // Next state of the timer
    always_comb begin
        divider_next = divider_reg;
        tima_next    = tima_reg;
        tma_next     = tma_reg;
        tac_next     = tac_reg;
        delay_next   = delay_reg;
        ctl_next     = ctl_reg;
        count_next   = count_reg;
        irq_next     = irq_reg;
        do_bump      = 1'b0;

        if (cmd.start) begin
            count_next = 8'd0;
            irq_next   = 1'b0;
            case (hctmr_pkg::act_t'(s_action))
                hctmr_pkg::ACT_TICK: begin
                    ctl_next   = tac_reg;
                    count_next = s_cycles;
                    // Shorten a pending reload first
                    if (delay_reg != 3'd0) begin
                        if (s_cycles < {5'd0, delay_reg}) begin
                            delay_next = delay_reg - s_cycles[2:0];
                        end else begin
                            delay_next = 3'd0;
                            tima_next  = tma_reg;
                            irq_next   = 1'b1;
                        end
                    end
                end
                hctmr_pkg::ACT_WR_DIV: begin
                    divider_next = 16'd0;
                    do_bump      = timer_in(tac_reg, divider_reg);
                end
                hctmr_pkg::ACT_WR_TAC: begin
                    tac_next = s_write_data[2:0];
                    do_bump  = timer_in(tac_reg, divider_reg)
                               && !timer_in(s_write_data[2:0], divider_reg);
                end
                hctmr_pkg::ACT_WR_TIMA: begin
                    tima_next = s_write_data;
                end
                hctmr_pkg::ACT_WR_TMA: begin
                    tma_next = s_write_data;
                end
                default: begin
                end
            endcase
        end else if (cmd.step) begin
            // Advance the divider by one and count down the tick
            divider_next = divider_inc;
            count_next   = count_reg - 8'd1;
            do_bump      = timer_in(ctl_reg, divider_reg) && !timer_in(ctl_reg, divider_inc);
        end

        // Increment TIMA on a falling edge, ignored while a reload is pending
        if (do_bump && delay_reg == 3'd0) begin
            if (tima_reg == hctmr_pkg::TIMA_MAX) begin
                tima_next  = 8'd0;
                delay_next = hctmr_pkg::RELOAD_CYCLES;
            end else begin
                tima_next = tima_reg + 8'd1;
            end
        end
    end

    // Timer state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            divider_reg <= 16'd0;
            tima_reg    <= 8'd0;
            tma_reg     <= 8'd0;
            tac_reg     <= 3'd0;
            delay_reg   <= 3'd0;
            count_reg   <= 8'd0;
        end else begin
            divider_reg <= divider_next;
            tima_reg    <= tima_next;
            tma_reg     <= tma_next;
            tac_reg     <= tac_next;
            delay_reg   <= delay_next;
            count_reg   <= count_next;
        end
    end

    // Per-item working registers
    always_ff @(posedge aclk) begin
        ctl_reg <= ctl_next;
        irq_reg <= irq_next;
    end

    // Capture the result beat
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            div_out_reg  <= divider_reg[15:8];
            tima_out_reg <= tima_reg;
            tma_out_reg  <= tma_reg;
            tac_out_reg  <= tac_reg;
            irq_out_reg  <= irq_reg;
        end
    end

    assign status.count_zero = (count_reg == 8'd0);
    assign m_div_value  = div_out_reg;
    assign m_tima_value = tima_out_reg;
    assign m_tma_value  = tma_out_reg;
    assign m_tac_value  = tac_out_reg;
    assign m_timer_irq  = irq_out_reg;

endmodule
`default_nettype wire

/* sim/handheld_console_timer_top_tb.sv */
`timescale 1ns / 1ps
module handheld_console_timer_top_tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 270;
    localparam int MAX_SEND_GAP   = 40;

    // TAC fields
    localparam logic [2:0] TAC_ENABLE = 3'b100;
    localparam logic [1:0] RATE_1024  = 2'd0;
    localparam logic [1:0] RATE_16    = 2'd1;
    localparam logic [1:0] RATE_64    = 2'd2;
    localparam logic [1:0] RATE_256   = 2'd3;

    // Action codes the block must treat as no-ops
    localparam logic [2:0] ACT_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] ACT_UNUSED_LAST  = 3'd7;

    typedef struct packed {
        logic [7:0] div_value;
        logic [7:0] tima_value;
        logic [7:0] tma_value;
        logic [2:0] tac_value;
        logic       timer_irq;
    } timer_result_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [2:0] s_action = '0;
    logic [7:0] s_cycles = '0;
    logic [7:0] s_write_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_div_value;
    logic [7:0] m_tima_value;
    logic [7:0] m_tma_value;
    logic [2:0] m_tac_value;
    logic       m_timer_irq;

    // Timer state mirrored by the predictor
    logic [15:0] model_div;
    logic [7:0]  model_tima;
    logic [7:0]  model_tma;
    logic [2:0]  model_tac;
    logic [2:0]  model_reload;

    timer_result_t expected_results[$];
    timer_result_t head_result;
    int error_count   = 0;
    int items_sent    = 0;
    int idle_cycles   = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;

    handheld_console_timer_top u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_cycles     (s_cycles),
        .s_write_data (s_write_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_div_value  (m_div_value),
        .m_tima_value (m_tima_value),
        .m_tma_value  (m_tma_value),
        .m_tac_value  (m_tac_value),
        .m_timer_irq  (m_timer_irq)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Timer input: the divider bit picked by TAC, forced low while disabled
    function automatic logic timer_input(input logic [2:0] ctl, input logic [15:0] div);
        if (!(ctl & TAC_ENABLE))
            return 1'b0;
        case (ctl[1:0])
            RATE_1024: return div[hctmr_pkg::SEL_BIT_0];
            RATE_16:   return div[hctmr_pkg::SEL_BIT_1];
            RATE_64:   return div[hctmr_pkg::SEL_BIT_2];
            default:   return div[hctmr_pkg::SEL_BIT_3];
        endcase
    endfunction

    // Increment TIMA unless a reload is pending; arm the reload on overflow
    function automatic void bump_tima();
        if (model_reload != 3'd0)
            return;
        if (model_tima == hctmr_pkg::TIMA_MAX) begin
            model_tima   = 8'd0;
            model_reload = hctmr_pkg::RELOAD_CYCLES;
        end else begin
            model_tima = model_tima + 8'd1;
        end
    endfunction

    // Apply one action to the timer state and return the result it reports
    function automatic timer_result_t predict_timer(input logic [2:0] act,
                                                    input logic [7:0] cyc,
                                                    input logic [7:0] wdata);
        timer_result_t r;
        logic [2:0]    ctl;
        logic          was_high;
        r.timer_irq = 1'b0;
        case (act)
            hctmr_pkg::ACT_TICK: begin
                ctl = model_tac;
                // Drain a pending reload before counting
                if (model_reload != 3'd0) begin
                    if (cyc < model_reload) begin
                        model_reload = model_reload - cyc[2:0];
                    end else begin
                        model_reload = 3'd0;
                        model_tima   = model_tma;
                        r.timer_irq  = 1'b1;
                    end
                end
                for (int n = 0; n < cyc; n++) begin
                    was_high  = timer_input(ctl, model_div);
                    model_div = model_div + 16'd1;
                    if (was_high && !timer_input(ctl, model_div))
                        bump_tima();
                end
            end
            hctmr_pkg::ACT_WR_DIV: begin
                was_high  = timer_input(model_tac, model_div);
                model_div = 16'd0;
                if (was_high)
                    bump_tima();
            end
            hctmr_pkg::ACT_WR_TAC: begin
                was_high  = timer_input(model_tac, model_div);
                model_tac = wdata[2:0];
                if (was_high && !timer_input(model_tac, model_div))
                    bump_tima();
            end
            hctmr_pkg::ACT_WR_TIMA: model_tima = wdata;
            hctmr_pkg::ACT_WR_TMA:  model_tma  = wdata;
            default: ;
        endcase
        r.div_value  = model_div[15:8];
        r.tima_value = model_tima;
        r.tma_value  = model_tma;
        r.tac_value  = model_tac;
        return r;
    endfunction

    // Send one beat; called at a rising edge, returns at the edge that accepts it
    task automatic send_beat(input logic [2:0] act, input logic [7:0] cyc,
                             input logic [7:0] wdata);
        int gap;
        gap = 0;
        while (gap < MAX_SEND_GAP && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_action     <= act;
        s_cycles     <= cyc;
        s_write_data <= wdata;
        do @(posedge aclk); while (!s_ready);
        expected_results.push_back(predict_timer(act, cyc, wdata));
        items_sent++;
    endtask

    task automatic test_tick_extremes();
        send_beat(hctmr_pkg::ACT_TICK, 8'd0, 8'hFF);
        send_beat(hctmr_pkg::ACT_TICK, 8'hFF, 8'hA5);
        send_beat(hctmr_pkg::ACT_TICK, 8'd1, 8'h00);
    endtask

    task automatic test_register_writes();
        send_beat(hctmr_pkg::ACT_WR_TMA, 8'hFF, 8'hFF);
        send_beat(hctmr_pkg::ACT_WR_TIMA, 8'h00, 8'h00);
        // Upper data bits must be dropped by TAC
        send_beat(hctmr_pkg::ACT_WR_TAC, 8'h5A, 8'hF8);
        send_beat(hctmr_pkg::ACT_WR_DIV, 8'hFF, 8'hFF);
    endtask

    // DIV reset, TAC disable and TAC rate change each make the input fall
    task automatic test_falling_edge_writes();
        send_beat(hctmr_pkg::ACT_WR_TAC, 8'd0, {5'd0, TAC_ENABLE | RATE_16});
        send_beat(hctmr_pkg::ACT_TICK, 8'd8, 8'd0);
        send_beat(hctmr_pkg::ACT_WR_DIV, 8'd0, 8'd0);
        send_beat(hctmr_pkg::ACT_TICK, 8'd8, 8'd0);
        send_beat(hctmr_pkg::ACT_WR_TAC, 8'd0, {5'd0, 1'b0, RATE_16});
        send_beat(hctmr_pkg::ACT_WR_TAC, 8'd0, {5'd0, TAC_ENABLE | RATE_16});
        send_beat(hctmr_pkg::ACT_WR_TAC, 8'd0, {5'd0, TAC_ENABLE | RATE_64});
    endtask

    // Overflow, delay shortened across ticks, TIMA write during the delay, reload
    task automatic test_overflow_reload();
        send_beat(hctmr_pkg::ACT_WR_TAC, 8'd0, {5'd0, TAC_ENABLE | RATE_16});
        send_beat(hctmr_pkg::ACT_WR_TMA, 8'd0, 8'hAB);
        send_beat(hctmr_pkg::ACT_WR_TIMA, 8'd0, 8'hFF);
        send_beat(hctmr_pkg::ACT_WR_DIV, 8'd0, 8'd0);
        send_beat(hctmr_pkg::ACT_TICK, 8'd16, 8'd0);
        send_beat(hctmr_pkg::ACT_TICK, 8'd0, 8'd0);
        send_beat(hctmr_pkg::ACT_TICK, 8'd2, 8'd0);
        send_beat(hctmr_pkg::ACT_WR_TIMA, 8'd0, 8'h55);
        send_beat(hctmr_pkg::ACT_TICK, 8'd3, 8'd0);
    endtask

    task automatic test_unknown_actions();
        for (int a = ACT_UNUSED_FIRST; a <= ACT_UNUSED_LAST; a++)
            send_beat(3'(a), 8'hFF, 8'($urandom));
    endtask

    // Mostly overflow-oriented sequences with random content, plus raw noise
    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int item_target);
        int         stop_at;
        int         burst;
        logic [1:0] rate;
        logic [7:0] tick_len;
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
        stop_at       = items_sent + item_target;
        while (items_sent < stop_at) begin
            if ($urandom_range(99) < 75) begin
                rate = ($urandom_range(3) == 0) ? 2'($urandom) :
                       ($urandom_range(1) ? RATE_16 : RATE_64);
                send_beat(hctmr_pkg::ACT_WR_TAC, 8'($urandom),
                          {5'($urandom), TAC_ENABLE | {1'b0, rate}});
                if ($urandom_range(1))
                    send_beat(hctmr_pkg::ACT_WR_TMA, 8'($urandom), 8'($urandom));
                send_beat(hctmr_pkg::ACT_WR_TIMA, 8'($urandom),
                          ($urandom_range(3) == 0) ? 8'($urandom) :
                          8'($urandom_range(255, 248)));
                if ($urandom_range(3) == 0)
                    send_beat(hctmr_pkg::ACT_WR_DIV, 8'($urandom), 8'($urandom));
                burst = $urandom_range(12, 3);
                repeat (burst) begin
                    if ($urandom_range(99) < 85) begin
                        case ($urandom_range(9))
                            0:       tick_len = 8'($urandom);
                            1, 2, 3, 4: tick_len = 8'($urandom_range(7));
                            default: tick_len = 8'($urandom_range(24));
                        endcase
                        send_beat(hctmr_pkg::ACT_TICK, tick_len, 8'($urandom));
                    end else begin
                        send_beat(3'($urandom_range(hctmr_pkg::ACT_WR_TMA,
                                                    hctmr_pkg::ACT_WR_DIV)),
                                  8'($urandom), 8'($urandom));
                    end
                end
            end else begin
                send_beat(3'($urandom), 8'($urandom), 8'($urandom));
            end
        end
    endtask

    // Compare each result beat with the oldest prediction; randomize receiver stalls
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result beat with no pending item");
                error_count++;
            end else begin
                head_result = expected_results.pop_front();
                if (m_div_value !== head_result.div_value) begin
                    $error("div_value: expected %0h, actual %0h",
                           head_result.div_value, m_div_value);
                    error_count++;
                end
                if (m_tima_value !== head_result.tima_value) begin
                    $error("tima_value: expected %0h, actual %0h",
                           head_result.tima_value, m_tima_value);
                    error_count++;
                end
                if (m_tma_value !== head_result.tma_value) begin
                    $error("tma_value: expected %0h, actual %0h",
                           head_result.tma_value, m_tma_value);
                    error_count++;
                end
                if (m_tac_value !== head_result.tac_value) begin
                    $error("tac_value: expected %0h, actual %0h",
                           head_result.tac_value, m_tac_value);
                    error_count++;
                end
                if (m_timer_irq !== head_result.timer_irq) begin
                    $error("timer_irq: expected %0h, actual %0h",
                           head_result.timer_irq, m_timer_irq);
                    error_count++;
                end
            end
        end
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Abort when no beat moves on either channel for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        model_div    = '0;
        model_tima   = '0;
        model_tma    = '0;
        model_tac    = '0;
        model_reload = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_tick_extremes();
        test_register_writes();
        test_falling_edge_writes();
        test_overflow_reload();
        test_unknown_actions();
        test_random_traffic(0, 0, 400);
        test_random_traffic(56, 0, 400);
        test_random_traffic(0, 56, 400);
        test_random_traffic(14, 14, 400);
        s_valid <= 1'b0;

        // Drain outstanding results, then watch for stray beats
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* sim.f */
hdl/hctmr_pkg.sv
hdl/hctmr_ctrl.sv
hdl/hctmr_dp.sv
hdl/handheld_console_timer_top.sv
sim/handheld_console_timer_top_tb.sv
